FILE: src/phi_idf_pkg.sv
package phi_idf_pkg;

    // Fixed field widths of the item ports.
    localparam int INDEX_W        = 6;
    localparam int MASK_W         = 64;
    localparam int MAX_BLOCKS_DEF = 64;

    // Item operation codes.
    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // Top-level control states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    // Frontier row read request from the worklist to the table.
    typedef struct packed {
        logic               en;
        logic [INDEX_W-1:0] addr;
    } rd_req_t;

    // Worklist status toward the controller.
    typedef struct packed {
        logic busy;
        logic done;
    } wl_status_t;

endpackage

FILE: src/phi_placement_idf_core.sv
// Load item: writes one frontier row if its block index is below MAX_BLOCKS; returns no result.
// Query item: walks the worklist from the def sites with one table read per pop; each block
// is queued at most once, so there are at most MAX_BLOCKS pops, and the placed set is the result.
// The walk ends only once nothing is pending and no row is in flight.
// One item at a time; the result register lets the next item in while a result waits.
// Reset (synchronous, active low) marks every frontier row empty and clears the worklist.
module phi_placement_idf_core #(
    parameter int MAX_BLOCKS = phi_idf_pkg::MAX_BLOCKS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_operation,
    input  logic [phi_idf_pkg::INDEX_W-1:0] s_block_index,
    input  logic [phi_idf_pkg::MASK_W-1:0]  s_frontier_row,
    input  logic [phi_idf_pkg::MASK_W-1:0]  s_def_site_mask,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [phi_idf_pkg::MASK_W-1:0]  m_phi_mask
);
    import phi_idf_pkg::*;

    state_t                state_reg, state_next;
    logic                  m_valid_reg, m_valid_next;
    logic [MASK_W-1:0]     m_phi_mask_reg;
    logic                  out_load;

    logic                  accept;
    logic                  wr_en;
    logic                  start;
    rd_req_t               rd_req;
    wl_status_t            wl_status;
    logic [MAX_BLOCKS-1:0] rd_data;
    logic [MAX_BLOCKS-1:0] placed;
    logic                  slot_free;

    // Input decode.
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign wr_en   = accept && (op_t'(s_operation) == OP_LOAD)
                     && ({1'b0, s_block_index} < (INDEX_W + 1)'(MAX_BLOCKS));
    assign start   = accept && (op_t'(s_operation) == OP_QUERY);

    phi_idf_frontier_mem #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_mem (
        .aclk   (aclk),
        .aresetn(aresetn),
        .wr_en  (wr_en),
        .wr_addr(s_block_index),
        .wr_data(s_frontier_row[MAX_BLOCKS-1:0]),
        .rd_req (rd_req),
        .rd_data(rd_data)
    );

    phi_idf_worklist #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_worklist (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (start),
        .defs   (s_def_site_mask[MAX_BLOCKS-1:0]),
        .rd_data(rd_data),
        .rd_req (rd_req),
        .status (wl_status),
        .placed (placed)
    );

    // Controller and result register handshake.
    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        out_load     = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (wl_status.done) begin
                    if (slot_free) begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload, widened to the port.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_phi_mask_reg <= MASK_W'(placed);
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_phi_mask = m_phi_mask_reg;

endmodule

FILE: src/phi_idf_frontier_mem.sv
module phi_idf_frontier_mem #(
    parameter int MAX_BLOCKS = phi_idf_pkg::MAX_BLOCKS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [phi_idf_pkg::INDEX_W-1:0] wr_addr,
    input  logic [MAX_BLOCKS-1:0]         wr_data,
    input  phi_idf_pkg::rd_req_t          rd_req,
    output logic [MAX_BLOCKS-1:0]         rd_data
);
    import phi_idf_pkg::*;

    localparam int ADDR_W = $clog2(MAX_BLOCKS);

    logic [MAX_BLOCKS-1:0] mem [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] row_valid_reg;
    logic [MAX_BLOCKS-1:0] rd_raw_reg;
    logic                  rd_valid_reg;

    // Row storage and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr[ADDR_W-1:0]] <= wr_data;
        end
        if (rd_req.en) begin
            rd_raw_reg <= mem[rd_req.addr[ADDR_W-1:0]];
        end
    end

    // One valid bit per row; a row never loaded reads as an empty frontier.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                row_valid_reg[wr_addr[ADDR_W-1:0]] <= 1'b1;
            end
            if (rd_req.en) begin
                rd_valid_reg <= row_valid_reg[rd_req.addr[ADDR_W-1:0]];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_raw_reg : '0;

endmodule

FILE: src/phi_idf_worklist.sv
module phi_idf_worklist #(
    parameter int MAX_BLOCKS = phi_idf_pkg::MAX_BLOCKS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [MAX_BLOCKS-1:0]     defs,
    input  logic [MAX_BLOCKS-1:0]     rd_data,
    output phi_idf_pkg::rd_req_t      rd_req,
    output phi_idf_pkg::wl_status_t   status,
    output logic [MAX_BLOCKS-1:0]     placed
);
    import phi_idf_pkg::*;

    logic [MAX_BLOCKS-1:0] pending_reg, pending_next;
    logic [MAX_BLOCKS-1:0] queued_reg, queued_next;
    logic [MAX_BLOCKS-1:0] placed_reg, placed_next;
    logic                  busy_reg, busy_next;
    logic                  inflight_reg, inflight_next;
    logic                  done_reg, done_next;

    logic [MAX_BLOCKS-1:0] low_bit;
    logic [INDEX_W-1:0]    pop_idx;
    logic                  pop;
    logic [MAX_BLOCKS-1:0] row;
    logic [MAX_BLOCKS-1:0] fresh;
    logic [MAX_BLOCKS-1:0] enter;

    // Pick the lowest pending block and encode its index.
    always_comb begin
        low_bit = pending_reg & (~pending_reg + MAX_BLOCKS'(1));
        pop_idx = '0;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (low_bit[i]) begin
                pop_idx = pop_idx | INDEX_W'(i);
            end
        end
    end

    assign pop         = busy_reg && (pending_reg != '0);
    assign rd_req.en   = pop;
    assign rd_req.addr = pop_idx;

    // Merge the row that returns in the cycle after its pop.
    assign row   = inflight_reg ? rd_data : '0;
    assign fresh = row & ~placed_reg;
    assign enter = fresh & ~queued_reg;

    always_comb begin
        pending_next  = pending_reg;
        queued_next   = queued_reg;
        placed_next   = placed_reg;
        busy_next     = busy_reg;
        inflight_next = 1'b0;
        done_next     = 1'b0;
        if (start) begin
            pending_next = defs;
            queued_next  = defs;
            placed_next  = '0;
            busy_next    = 1'b1;
        end else if (busy_reg) begin
            pending_next  = (pending_reg & ~(pop ? low_bit : '0)) | enter;
            queued_next   = queued_reg | enter;
            placed_next   = placed_reg | fresh;
            inflight_next = pop;
            // The worklist has drained once nothing is pending or in flight.
            if (!pop && !inflight_reg) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg  <= '0;
            queued_reg   <= '0;
            placed_reg   <= '0;
            busy_reg     <= 1'b0;
            inflight_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            pending_reg  <= pending_next;
            queued_reg   <= queued_next;
            placed_reg   <= placed_next;
            busy_reg     <= busy_next;
            inflight_reg <= inflight_next;
            done_reg     <= done_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign placed      = placed_reg;

endmodule
